// File: src/spectrum_log_scaler_smoother_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the spectrum log scaler and smoother
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_LOG_SCALER_SMOOTHER_TOP_MACROS_SVH
`define SPECTRUM_LOG_SCALER_SMOOTHER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SLSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("slss assertion failed");
`define SLSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("slss assertion failed");
`else
`define SLSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SLSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/slss_pkg.sv
// ----------------------------------------------------------------------------
// slss_pkg
// Types, constants and the gain table shared by the scaler and smoother.
// ----------------------------------------------------------------------------
package slss_pkg;

    localparam int COL_W   = 10;
    localparam int POWER_W = 32;
    localparam int LEVEL_W = 8;
    localparam int X_W     = 16;
    localparam int G_W     = 16;
    localparam int FRAC_W  = 16;

    localparam logic [32:0] POWER_BIAS      = 33'd100;
    localparam logic [14:0] LOG10_2_Q16     = 15'd19728;
    localparam logic [20:0] X_OFFSET_Q16    = 21'd131072;
    localparam logic [16:0] SCALE_PLAIN_Q12 = 17'd75366;
    localparam logic [8:0]  LEVEL_MAX       = 9'd160;
    localparam logic [7:0]  COLOR_MAX       = 8'd255;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] column;
        logic [X_W-1:0]   x;
    } x_item_t;

    typedef struct packed {
        logic               valid;
        logic [COL_W-1:0]   column;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] color;
    } res_item_t;

    // g(k) = 1 - exp(-0.05 k) in Q0.16; indexes past the end give the last entry.
    function automatic logic [G_W-1:0] gain_lut(input logic [5:0] idx);
        logic [G_W-1:0] g;
        case (idx)
            6'd0:  g = 16'd0;
            6'd1:  g = 16'd3196;
            6'd2:  g = 16'd6237;
            6'd3:  g = 16'd9129;
            6'd4:  g = 16'd11880;
            6'd5:  g = 16'd14497;
            6'd6:  g = 16'd16986;
            6'd7:  g = 16'd19354;
            6'd8:  g = 16'd21606;
            6'd9:  g = 16'd23748;
            6'd10: g = 16'd25786;
            6'd11: g = 16'd27725;
            6'd12: g = 16'd29569;
            6'd13: g = 16'd31323;
            6'd14: g = 16'd32992;
            6'd15: g = 16'd34579;
            6'd16: g = 16'd36089;
            6'd17: g = 16'd37525;
            6'd18: g = 16'd38891;
            6'd19: g = 16'd40191;
            6'd20: g = 16'd41427;
            6'd21: g = 16'd42602;
            6'd22: g = 16'd43721;
            6'd23: g = 16'd44785;
            6'd24: g = 16'd45797;
            6'd25: g = 16'd46760;
            6'd26: g = 16'd47675;
            6'd27: g = 16'd48546;
            6'd28: g = 16'd49375;
            6'd29: g = 16'd50163;
            6'd30: g = 16'd50913;
            6'd31: g = 16'd51626;
            default: g = 16'd52305;
        endcase
        return g;
    endfunction

endpackage

// File: src/slss_ram.sv
// ----------------------------------------------------------------------------
// slss_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module slss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/slss_log.sv
// ----------------------------------------------------------------------------
// slss_log
// Pipelined log10 term: x = log10(power + 100) - 2 in unsigned Q4.12.
// ----------------------------------------------------------------------------
module slss_log (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [slss_pkg::COL_W-1:0]   in_column,
    input  logic [slss_pkg::POWER_W-1:0] in_power,
    output slss_pkg::x_item_t            out_item
);

    localparam int SQ = slss_pkg::FRAC_W;

    // Stage 1: biased power.
    logic                       v1_valid_reg;
    logic [slss_pkg::COL_W-1:0] v1_col_reg;
    logic [32:0]                v1_reg;

    // Stage 2: leading one position.
    logic                       v2_valid_reg;
    logic [slss_pkg::COL_W-1:0] v2_col_reg;
    logic [32:0]                v2_reg;
    logic [5:0]                 e2_reg;
    logic [5:0]                 e2_next;

    // Normalized mantissa plus one stage per squaring step.
    logic                       sq_valid_reg [0:SQ];
    logic [slss_pkg::COL_W-1:0] sq_col_reg   [0:SQ];
    logic [31:0]                sq_m_reg     [0:SQ];
    logic [SQ-1:0]              sq_f_reg     [0:SQ];
    logic [5:0]                 sq_e_reg     [0:SQ];
    logic [32:0]                norm;

    logic                       l_valid_reg;
    logic [slss_pkg::COL_W-1:0] l_col_reg;
    logic [20:0]                l10_reg;
    logic [36:0]                l10_prod;

    logic                       x_valid_reg;
    logic [slss_pkg::COL_W-1:0] x_col_reg;
    logic [slss_pkg::X_W-1:0]   x_reg;
    logic [slss_pkg::X_W-1:0]   x_next;
    logic [20:0]                x_diff;

    always_comb begin
        e2_next = '0;
        for (int k = 0; k < 33; k++) begin
            if (v1_reg[k]) begin
                e2_next = 6'(k);
            end
        end
    end

    // Bit e lands at bit 32; dropping the lowest bit leaves Q1.31.
    assign norm = v2_reg << (6'd32 - e2_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            v1_col_reg <= in_column;
            v1_reg     <= {1'b0, in_power} + slss_pkg::POWER_BIAS;
            v2_col_reg <= v1_col_reg;
            v2_reg     <= v1_reg;
            e2_reg     <= e2_next;
            sq_col_reg[0] <= v2_col_reg;
            sq_m_reg[0]   <= norm[32:1];
            sq_f_reg[0]   <= '0;
            sq_e_reg[0]   <= e2_reg;
        end
    end

    for (genvar k = 0; k < SQ; k++) begin : g_sq
        logic [63:0] prod;
        logic [32:0] t;
        assign prod = sq_m_reg[k] * sq_m_reg[k];
        assign t    = prod[63:31];
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_col_reg[k+1] <= sq_col_reg[k];
                sq_e_reg[k+1]   <= sq_e_reg[k];
                sq_m_reg[k+1]   <= t[32] ? t[32:1] : t[31:0];
                sq_f_reg[k+1]   <= {sq_f_reg[k][SQ-2:0], t[32]};
            end
        end
    end

    assign l10_prod = {sq_e_reg[SQ], sq_f_reg[SQ]} * slss_pkg::LOG10_2_Q16;

    always_comb begin
        x_diff = l10_reg - slss_pkg::X_OFFSET_Q16;
        if (l10_reg < slss_pkg::X_OFFSET_Q16) begin
            x_next = '0;
        end else if (x_diff[20]) begin
            x_next = '1;
        end else begin
            x_next = x_diff[19:4];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            l_col_reg <= sq_col_reg[SQ];
            l10_reg   <= l10_prod[36:16];
            x_col_reg <= l_col_reg;
            x_reg     <= x_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_valid_reg <= 1'b0;
            v2_valid_reg <= 1'b0;
            for (int k = 0; k <= SQ; k++) begin
                sq_valid_reg[k] <= 1'b0;
            end
            l_valid_reg <= 1'b0;
            x_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_valid_reg    <= in_valid;
            v2_valid_reg    <= v1_valid_reg;
            sq_valid_reg[0] <= v2_valid_reg;
            for (int k = 0; k < SQ; k++) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
            l_valid_reg <= sq_valid_reg[SQ];
            x_valid_reg <= l_valid_reg;
        end
    end

    assign out_item.valid  = x_valid_reg;
    assign out_item.column = x_col_reg;
    assign out_item.x      = x_reg;

endmodule

// File: src/slss_smooth.sv
// ----------------------------------------------------------------------------
// slss_smooth
// Gain lookup, per-column averaging store, level scaling and output register.
// ----------------------------------------------------------------------------
`include "spectrum_log_scaler_smoother_top_macros.svh"

module slss_smooth #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                smooth_en,
    input  slss_pkg::x_item_t   in_item,
    output slss_pkg::res_item_t out_item,
    output logic                clear_busy
);

    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int PAD_W = 32 - slss_pkg::COL_W;
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_COLUMNS - 1);

    // Gain stage.
    logic                       q1_valid_reg;
    logic [slss_pkg::COL_W-1:0] q1_col_reg;
    logic [slss_pkg::X_W-1:0]   q1_x_reg;
    logic [slss_pkg::G_W-1:0]   q1_g_reg;
    logic [slss_pkg::G_W-1:0]   g_next;
    logic [5:0]                 g_idx;
    logic [slss_pkg::G_W-1:0]   g_lo;
    logic [slss_pkg::G_W-1:0]   g_hi;
    logic [slss_pkg::G_W-1:0]   g_step;
    logic [25:0]                g_prod;

    // Plain scaling stage; issues the store read.
    logic                       q2_valid_reg;
    logic [slss_pkg::COL_W-1:0] q2_col_reg;
    logic [slss_pkg::X_W-1:0]   q2_x_reg;
    logic [slss_pkg::G_W-1:0]   q2_g_reg;
    logic [8:0]                 q2_plain_reg;
    logic [32:0]                plain_prod;

    // Averaging stage; writes the store back.
    logic                       q3_valid_reg;
    logic [slss_pkg::COL_W-1:0] q3_col_reg;
    logic [8:0]                 q3_plain_reg;
    logic                       held;
    logic [15:0]                s_cur;
    logic [16:0]                s_diff;
    logic [33:0]                s_prod;
    logic [17:0]                s_sum;

    logic                       fwd_valid_reg;
    logic [AW-1:0]              fwd_addr_reg;
    logic [15:0]                fwd_data_reg;

    logic                       clr_busy_reg;
    logic [AW-1:0]              clr_cnt_reg;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [15:0]                ram_wdata;
    logic [15:0]                ram_rdata;
    logic                       upd_write;

    slss_pkg::res_item_t        out_reg;
    slss_pkg::res_item_t        out_next;
    logic [20:0]                smooth_scaled;
    logic [8:0]                 level_raw;
    logic [8:0]                 level_sat;

    always_comb begin
        g_idx  = in_item.x[15:10];
        g_lo   = slss_pkg::gain_lut(g_idx);
        g_hi   = slss_pkg::gain_lut(g_idx + 6'd1);
        g_step = g_hi - g_lo;
        g_prod = g_step * in_item.x[9:0];
        if (g_idx[5]) begin
            g_next = slss_pkg::gain_lut(g_idx);
        end else begin
            g_next = g_lo + g_prod[25:10];
        end
    end

    assign plain_prod = q1_x_reg * slss_pkg::SCALE_PLAIN_Q12;

    always_ff @(posedge aclk) begin
        if (adv) begin
            q1_col_reg   <= in_item.column;
            q1_x_reg     <= in_item.x;
            q1_g_reg     <= g_next;
            q2_col_reg   <= q1_col_reg;
            q2_x_reg     <= q1_x_reg;
            q2_g_reg     <= q1_g_reg;
            q2_plain_reg <= plain_prod[32:24];
        end
    end

    slss_ram #(
        .WIDTH(16),
        .DEPTH(MAX_COLUMNS)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (adv),
        .raddr(AW'(q2_col_reg)),
        .rdata(ram_rdata)
    );

    // The read and the previous item's write share an edge, so the last
    // write is forwarded when the addresses match.
    // s_new = s + floor((x - s) * g / 2^16), the same as the weighted sum.
    always_comb begin
        held = ({{PAD_W{1'b0}}, q3_col_reg} < 32'(MAX_COLUMNS));
        if (!held) begin
            s_cur = '0;
        end else if (fwd_valid_reg && (fwd_addr_reg == AW'(q3_col_reg))) begin
            s_cur = fwd_data_reg;
        end else begin
            s_cur = ram_rdata;
        end
    end

    // The averaging stage holds its operands in q3 regs loaded from q2;
    // the multiply sits between the q3 regs and the store write.
    logic [slss_pkg::X_W-1:0] q3_x_reg;
    logic [slss_pkg::G_W-1:0] q3_g_reg;

    always_comb begin
        s_diff = {1'b0, q3_x_reg} - {1'b0, s_cur};
        s_prod = $signed(s_diff) * $signed({1'b0, q3_g_reg});
        s_sum  = {2'b00, s_cur} + s_prod[33:16];
    end

    assign upd_write = adv && q3_valid_reg && smooth_en && held;

    always_comb begin
        if (clr_busy_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = upd_write;
            ram_waddr = AW'(q3_col_reg);
            ram_wdata = s_sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q3_col_reg   <= q2_col_reg;
            q3_x_reg     <= q2_x_reg;
            q3_g_reg     <= q2_g_reg;
            q3_plain_reg <= q2_plain_reg;
        end
        if (upd_write) begin
            fwd_addr_reg <= AW'(q3_col_reg);
            fwd_data_reg <= s_sum[15:0];
        end
    end

    // The averaging result reaches the level stage one register later.
    logic                       q4_valid_reg;
    logic [slss_pkg::COL_W-1:0] q4_col_reg;
    logic [15:0]                q4_sn_reg;
    logic [8:0]                 q4_plain_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            q4_col_reg   <= q3_col_reg;
            q4_sn_reg    <= s_sum[15:0];
            q4_plain_reg <= q3_plain_reg;
        end
    end

    always_comb begin
        smooth_scaled = {1'b0, q4_sn_reg, 4'b0000} + {3'b000, q4_sn_reg, 2'b00};
        level_raw     = smooth_en ? smooth_scaled[20:12] : q4_plain_reg;
        level_sat     = (level_raw > slss_pkg::LEVEL_MAX) ? slss_pkg::LEVEL_MAX : level_raw;
        out_next.valid  = q4_valid_reg;
        out_next.column = q4_col_reg;
        out_next.level  = level_sat[7:0];
        if (level_sat[8:6] != 3'b000) begin
            out_next.color = slss_pkg::COLOR_MAX;
        end else begin
            out_next.color = {level_sat[5:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.column <= out_next.column;
            out_reg.level  <= out_next.level;
            out_reg.color  <= out_next.color;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q1_valid_reg  <= 1'b0;
            q2_valid_reg  <= 1'b0;
            q3_valid_reg  <= 1'b0;
            q4_valid_reg  <= 1'b0;
            out_reg.valid <= 1'b0;
            fwd_valid_reg <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
        end else begin
            if (adv) begin
                q1_valid_reg  <= in_item.valid;
                q2_valid_reg  <= q1_valid_reg;
                q3_valid_reg  <= q2_valid_reg;
                q4_valid_reg  <= q3_valid_reg;
                out_reg.valid <= out_next.valid;
            end
            if (upd_write) begin
                fwd_valid_reg <= 1'b1;
            end
            if (clr_busy_reg) begin
                if (clr_cnt_reg == CLR_LAST) begin
                    clr_busy_reg <= 1'b0;
                end else begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                end
            end
        end
    end

    assign out_item   = out_reg;
    assign clear_busy = clr_busy_reg;

    `SLSS_ASSERT_IMPL(a_no_item_during_clear, aclk, aresetn, clr_busy_reg, !in_item.valid && !q3_valid_reg)
    `SLSS_ASSERT_IMPL(a_no_update_when_stalled, aclk, aresetn, !adv && !clr_busy_reg, !ram_we)
    `SLSS_ASSERT_IMPL(a_clear_covers_store, aclk, aresetn, $fell(clr_busy_reg), $past(clr_cnt_reg) == CLR_LAST)
    `SLSS_ASSERT_NEXT(a_update_arms_forward, aclk, aresetn, upd_write, fwd_valid_reg && fwd_data_reg == $past(s_sum[15:0]))

endmodule

// File: src/spectrum_log_scaler_smoother_top.sv
// ----------------------------------------------------------------------------
// spectrum_log_scaler_smoother_top
// Log scaling of FFT bin power to a trace level and waterfall color index.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock when the output side is ready and the store
// is not being cleared, and returns exactly one result transaction for each, in order, on
// m_tvalid. Most of the pipeline is the 16-stage squaring pipeline that forms the log2
// fraction, one multiplier per stage. After reset the column store is cleared one entry per
// cycle, which holds s_tready low until every entry is cleared. Mode changes through cfg_we
// must be made while idle.
module spectrum_log_scaler_smoother_top #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_wdata,       // smooth_enable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,         // column[9:0], power[41:10], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata          // column_out[9:0], level[17:10], color_index[25:18]
);

    logic                smooth_en_reg;
    logic                adv;
    logic                clear_busy;
    slss_pkg::x_item_t   x_item;
    slss_pkg::res_item_t res_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_en_reg <= 1'b0;
        end else if (cfg_we) begin
            smooth_en_reg <= cfg_wdata[0];
        end
    end

    // The whole pipeline moves whenever the output register can be loaded.
    assign adv      = !res_item.valid || m_tready;
    assign s_tready = adv && !clear_busy;

    slss_log u_log (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_tvalid && s_tready),
        .in_column(s_tdata[9:0]),
        .in_power (s_tdata[41:10]),
        .out_item (x_item)
    );

    slss_smooth #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_smooth (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .smooth_en (smooth_en_reg),
        .in_item   (x_item),
        .out_item  (res_item),
        .clear_busy(clear_busy)
    );

    assign m_tvalid = res_item.valid;
    assign m_tdata  = {6'd0, res_item.color, res_item.level, res_item.column};

endmodule

// File: dv/spectrum_log_scaler_smoother_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Checker for the spectrum log scaler and smoother
// Watches the input, result and register ports, computes the expected level
// and color index of every accepted transaction, and compares them in order.
// ----------------------------------------------------------------------------
module spectrum_log_scaler_smoother_checker #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    logic [15:0] avg_store [MAX_COLUMNS];
    logic        smoothing;
    logic [25:0] expected_q[$];

    localparam int unsigned GAIN_STEPS [33] = '{
        0, 3196, 6237, 9129, 11880, 14497, 16986, 19354,
        21606, 23748, 25786, 27725, 29569, 31323, 32992, 34579,
        36089, 37525, 38891, 40191, 41427, 42602, 43721, 44785,
        45797, 46760, 47675, 48546, 49375, 50163, 50913, 51626,
        52305
    };

    function automatic logic [15:0] log_q12(input logic [31:0] power);
        logic [63:0] v, m, l2, l10;
        int          e;
        logic [15:0] frac;
        v = {32'd0, power} + 64'd100;
        e = 32;
        while (e > 0 && v[e] == 1'b0) e--;
        if (e >= 31) m = v >> (e - 31);
        else m = v << (31 - e);
        frac = '0;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        l2 = (64'(e) << 16) | 64'(frac);
        l10 = (l2 * 64'd19728) >> 16;
        if (l10 < 64'd131072) return 16'd0;
        l10 = (l10 - 64'd131072) >> 4;
        if (l10 > 64'hFFFF) l10 = 64'hFFFF;
        return l10[15:0];
    endfunction

    function automatic logic [63:0] gain_for(input logic [15:0] x);
        int unsigned i, f, lo, hi;
        i = x >> 10;
        f = x & 16'h3FF;
        if (i >= 32) return GAIN_STEPS[32];
        lo = GAIN_STEPS[i];
        hi = GAIN_STEPS[i + 1];
        return lo + (((hi - lo) * f) >> 10);
    endfunction

    function automatic logic [25:0] scale_column(input logic [9:0] col,
                                                 input logic [31:0] power);
        logic [15:0] x;
        logic [63:0] s, g, sn, lvl, color;
        logic        held;
        x = log_q12(power);
        if (smoothing) begin
            held = int'(col) < MAX_COLUMNS;
            s = held ? 64'(avg_store[col]) : 64'd0;
            g = gain_for(x);
            sn = (s * (64'd65536 - g) + 64'(x) * g) >> 16;
            if (sn > 64'hFFFF) sn = 64'hFFFF;
            if (held) avg_store[col] = sn[15:0];
            lvl = (sn * 64'd20) >> 12;
        end else begin
            lvl = (64'(x) * 64'd75366) >> 24;
        end
        if (lvl > 64'd160) lvl = 64'd160;
        color = lvl * 4;
        if (color > 64'd255) color = 64'd255;
        return {color[7:0], lvl[7:0], col};
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        logic [25:0] exp_item;
        if (!aresetn) begin
            smoothing <= 1'b0;
            for (int i = 0; i < MAX_COLUMNS; i++) avg_store[i] = '0;
            expected_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) smoothing <= cfg_wdata[0];
            if (s_tvalid && s_tready)
                expected_q.push_back(scale_column(s_tdata[9:0], s_tdata[41:10]));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transaction %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_item = expected_q.pop_front();
                    if (m_tdata[25:0] !== exp_item || m_tdata[31:26] !== 6'd0) begin
                        if (fail_count < 10)
                            $display("mismatch: column %0d/%0d level %0d/%0d color %0d/%0d",
                                     exp_item[9:0], m_tdata[9:0], exp_item[17:10],
                                     m_tdata[17:10], exp_item[25:18], m_tdata[25:18]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: dv/spectrum_log_scaler_smoother_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the spectrum log scaler and smoother
// Drives directed and random column/power transactions in both modes with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module spectrum_log_scaler_smoother_top_tb;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [0:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending;
    bit          stall_enable;

    spectrum_log_scaler_smoother_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    spectrum_log_scaler_smoother_checker checker_i (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("spectrum_log_scaler_smoother_top_tb failed");
        $finish;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 2);
    endfunction

    // Output stalls, switched off during some stretches.
    always @(posedge aclk) begin
        if (!aresetn || !stall_enable) m_tready <= 1'b1;
        else if ($urandom_range(0, 29) == 0) m_tready <= 1'b0;
        else if ($urandom_range(0, 2) == 0) m_tready <= 1'b1;
    end

    // s_tvalid stays high from one transaction to the next when there is no gap.
    task automatic send_power(input logic [9:0] col, input logic [31:0] power);
        int gap;
        gap = stall_enable ? gap_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, power, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_mode(input logic mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] random_power();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 300);
            1: return $urandom >> $urandom_range(0, 31);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int count, input int col_span);
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) stall_enable = ($urandom_range(0, 3) != 0);
            send_power(10'($urandom_range(0, col_span)), random_power());
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        stall_enable = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes in plain mode, then smoothing on a few columns.
        send_power(10'd0, 32'd0);
        send_power(10'd1023, 32'hFFFF_FFFF);
        send_power(10'd512, 32'd900);
        send_power(10'd1, 32'd1);
        send_power(10'h2AA, 32'h5555_5555);
        send_power(10'h155, 32'hAAAA_AAAA);
        drain_results();
        set_mode(1'b1);
        for (int i = 0; i < 6; i++) send_power(10'd3, 32'hFFFF_FFFF);
        send_power(10'd3, 32'd0);
        send_power(10'd1023, 32'hFFFF_FFFF);
        send_power(10'd1023, 32'd12345);
        send_power(10'd0, 32'd0);
        send_power(10'd4, 32'd1_000_000);
        drain_results();
        set_mode(1'b0);
        send_power(10'd3, 32'd77);
        drain_results();

        // Random: smoothing over a handful of columns reaches settled averages.
        set_mode(1'b1);
        run_random(200, 15);
        drain_results();
        set_mode(1'b0);
        run_random(150, 1023);
        drain_results();
        set_mode(1'b1);
        run_random(200, 1023);
        drain_results();

        if (fail_count == 0) begin
            $display("spectrum_log_scaler_smoother_top_tb passed");
        end else begin
            $display("spectrum_log_scaler_smoother_top_tb failed");
        end
        $finish;
    end

endmodule
